FILE: rtl/ngsc_pkg.sv
package ngsc_pkg;

	// field widths fixed by the word formats
	localparam int unsigned POS_W = 6;
	localparam int unsigned BUFFER_DEPTH_DEF = 64;

	// request opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_STAT = 2'd2;

	// characters of interest
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
	} req_word_t;

	typedef struct packed {
		logic [7:0]       data_char;
		logic [POS_W-1:0] position;
		logic             last;
		logic             good;
	} rsp_word_t;

	// controller to datapath and parser
	typedef struct packed {
		logic             byte_take;
		logic             rd_start;
		logic             stat;
		logic             rd_issue;
		logic             rd_last;
		logic [POS_W-1:0] rd_addr;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic adv;
	} dp_stat_t;

	// parser to buffer
	typedef struct packed {
		logic             we;
		logic             clr;
		logic [POS_W-1:0] addr;
		logic [7:0]       data;
	} wr_cmd_t;

	// letters, digits and , $ . * pass the filter
	function automatic logic char_ok(input logic [7:0] c);
		logic ok;
		ok = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			((c >= 8'h30) && (c <= 8'h39)) ||
			(c == CH_COMMA) || (c == CH_DOLLAR) || (c == CH_DOT) || (c == CH_STAR);
		return ok;
	endfunction

endpackage

FILE: rtl/ngsc_parse.sv
module ngsc_parse #(
	parameter int unsigned BUFFER_DEPTH = ngsc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cap_en,
	input  logic [7:0]          rx_byte,
	input  ngsc_pkg::ctrl_cmd_t cmd,
	output ngsc_pkg::wr_cmd_t   wr,
	output logic                good
);
	import ngsc_pkg::*;

	localparam int unsigned WI = $clog2(BUFFER_DEPTH + 1);

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_DOLLAR = 4'd1;
	localparam logic [3:0] ST_G1     = 4'd2;
	localparam logic [3:0] ST_P      = 4'd3;
	localparam logic [3:0] ST_G2     = 4'd4;
	localparam logic [3:0] ST_G3     = 4'd5;
	localparam logic [3:0] ST_A      = 4'd6;
	localparam logic [3:0] ST_COMMA  = 4'd7;
	localparam logic [3:0] ST_DATA   = 4'd8;
	localparam logic [3:0] ST_WAIT   = 4'd9;

	logic [3:0]    ps_q, ps_d;
	logic [WI-1:0] widx_q, widx_d;
	logic          good_q, good_d;
	logic          rdone_q, rdone_d;
	logic          take;

	assign take = cmd.byte_take && cap_en && char_ok(rx_byte);

	// sentence matcher
	always_comb begin
		ps_d    = ps_q;
		widx_d  = widx_q;
		good_d  = good_q;
		rdone_d = rdone_q;
		wr.we   = 1'b0;
		wr.clr  = 1'b0;
		wr.addr = POS_W'(widx_q);
		wr.data = rx_byte;
		if (cmd.rd_start) begin
			rdone_d = 1'b1;
		end
		if (take) begin
			unique case (ps_q)
				ST_INIT: begin
					wr.clr  = 1'b1;
					ps_d    = ST_DOLLAR;
					rdone_d = 1'b0;
					widx_d  = '0;
				end
				ST_DOLLAR: begin
					if (rx_byte == CH_DOLLAR) ps_d = ST_G1;
				end
				ST_G1, ST_P, ST_G2, ST_G3, ST_A: begin
					priority if ((ps_q == ST_G1 && rx_byte == CH_G) ||
						(ps_q == ST_P && rx_byte == CH_P) ||
						(ps_q == ST_G2 && rx_byte == CH_G) ||
						(ps_q == ST_G3 && rx_byte == CH_G) ||
						(ps_q == ST_A && rx_byte == CH_A)) begin
						ps_d = ps_q + 4'd1;
					end else begin
						ps_d    = ST_DOLLAR;
						rdone_d = 1'b0;
					end
				end
				ST_COMMA: begin
					ps_d    = ST_DOLLAR;
					rdone_d = 1'b0;
					if (rx_byte == CH_COMMA) begin
						ps_d   = ST_DATA;
						widx_d = '0;
					end
				end
				ST_DATA: begin
					if (widx_q < WI'(BUFFER_DEPTH)) begin
						wr.we  = 1'b1;
						widx_d = widx_q + 1'b1;
					end
					if (rx_byte == CH_DOLLAR) begin
						good_d = 1'b1;
						ps_d   = ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rdone_q) begin
						good_d  = 1'b0;
						ps_d    = ST_DOLLAR;
						rdone_d = 1'b0;
					end
				end
				default: begin
					ps_d    = ST_DOLLAR;
					rdone_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q    <= ST_INIT;
			widx_q  <= '0;
			good_q  <= 1'b1;
			rdone_q <= 1'b0;
		end else begin
			ps_q    <= ps_d;
			widx_q  <= widx_d;
			good_q  <= good_d;
			rdone_q <= rdone_d;
		end
	end

	assign good = good_q;

endmodule

FILE: rtl/ngsc_ctrl.sv
module ngsc_ctrl #(
	parameter int unsigned BUFFER_DEPTH = ngsc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          op,
	input  ngsc_pkg::dp_stat_t  stat,
	output logic                req_ready,
	output ngsc_pkg::ctrl_cmd_t cmd
);
	import ngsc_pkg::*;

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic          st_q;
	logic [AW-1:0] cnt_q;
	logic          acc;

	assign req_ready = (st_q == S_IDLE) && stat.adv;
	assign acc       = req_valid && req_ready;

	// commands
	always_comb begin
		cmd.byte_take = acc && (op == OP_BYTE);
		cmd.rd_start  = acc && (op == OP_READ);
		cmd.stat      = acc && (op == OP_STAT);
		cmd.rd_issue  = (st_q == S_READ) && stat.adv;
		cmd.rd_last   = (cnt_q == AW'(BUFFER_DEPTH - 1));
		cmd.rd_addr   = POS_W'(cnt_q);
	end

	// read-out sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (cmd.rd_start) st_q <= S_READ;
				end
				S_READ: begin
					if (cmd.rd_issue) begin
						cnt_q <= cnt_q + 1'b1;
						if (cmd.rd_last) st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/ngsc_dp.sv
module ngsc_dp #(
	parameter int unsigned BUFFER_DEPTH = ngsc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ngsc_pkg::ctrl_cmd_t cmd,
	input  ngsc_pkg::wr_cmd_t   wr,
	input  logic                good,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output ngsc_pkg::rsp_word_t rsp,
	output ngsc_pkg::dp_stat_t  stat
);
	import ngsc_pkg::*;

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	logic [7:0]        mem [BUFFER_DEPTH];
	logic [BUFFER_DEPTH-1:0] vld_q;

	logic             s1_valid_q;
	logic             s1_stat_s1;
	logic             s1_last_s1;
	logic             s1_good_s1;
	logic             s1_vld_s1;
	logic [7:0]       s1_data_s1;
	logic [POS_W-1:0] s1_pos_s1;

	logic      out_valid_q;
	rsp_word_t out_q;
	logic      load_out;
	logic      issue;

	assign load_out = s1_valid_q && (!out_valid_q || rsp_ready);
	assign stat.adv = !s1_valid_q || load_out;
	assign issue    = cmd.rd_issue || cmd.stat;

	// buffer write port and registered read
	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.addr[AW-1:0]] <= wr.data;
		if (cmd.rd_issue) s1_data_s1 <= mem[cmd.rd_addr[AW-1:0]];
	end

	// per-entry valid bits: unwritten entries read as '$'
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.clr) begin
			vld_q <= '0;
		end else if (wr.we) begin
			vld_q[wr.addr[AW-1:0]] <= 1'b1;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (issue) begin
			s1_valid_q <= 1'b1;
		end else if (load_out) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_stat_s1 <= cmd.stat;
			s1_last_s1 <= cmd.stat || cmd.rd_last;
			s1_good_s1 <= good;
			s1_vld_s1  <= vld_q[cmd.rd_addr[AW-1:0]];
			s1_pos_s1  <= cmd.stat ? '0 : cmd.rd_addr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			priority if (s1_stat_s1) out_q.data_char <= 8'h00;
			else if (s1_vld_s1) out_q.data_char <= s1_data_s1;
			else out_q.data_char <= CH_DOLLAR;
			out_q.position <= s1_pos_s1;
			out_q.last     <= s1_last_s1;
			out_q.good     <= s1_good_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/nmea_gga_sentence_capture.sv
// channel  | handshake             | word
// ---------+-----------------------+------------------------------------
// request  | req_valid / req_ready | req: op, rx_byte
// response | rsp_valid / rsp_ready | rsp: data_char, position, last, good
// config   | cfg_we                | cfg_wdata: capture_enable
//
// A received byte or status query is accepted as a single request; a read-out closes the
// request side while BUFFER_DEPTH buffer reads go out, one per cycle unless the response
// side stalls, through the single read port; the BUFFER_DEPTH words then leave through a
// read stage and output register. Reset marks all buffer entries as unwritten so they
// read as '$'; no clearing pass. A stalled response, once the read stage is full, holds
// the read sequencer and the request side.
module nmea_gga_sentence_capture #(
	parameter int unsigned BUFFER_DEPTH = ngsc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ngsc_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ngsc_pkg::rsp_word_t rsp,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import ngsc_pkg::*;

	logic      cap_en_q;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	wr_cmd_t   wr;
	logic      good;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q <= 1'b0;
		end else if (cfg_we) begin
			cap_en_q <= cfg_wdata;
		end
	end

	ngsc_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op        (req.op),
		.stat      (stat),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	ngsc_parse #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap_en  (cap_en_q),
		.rx_byte (req.rx_byte),
		.cmd     (cmd),
		.wr      (wr),
		.good    (good)
	);

	ngsc_dp #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr        (wr),
		.good      (good),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.stat      (stat)
	);

	// a read-out request closes the request side on the next cycle
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.op == OP_READ) |=> !req_ready)
		else $error("request accepted right after a read-out request");

	// sequencer reads never overlap an accepted request
	a_issue_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !req_ready)
		else $error("buffer read issued while requests are accepted");

	// a status word carries no character
	a_stat_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last && (rsp.position != POS_W'(BUFFER_DEPTH - 1))
		|-> (rsp.data_char == 8'h00) && (rsp.position == '0))
		else $error("status word with nonzero payload");

	// buffer writes and clears only follow an accepted byte
	a_wr_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.we || wr.clr) |-> cmd.byte_take && cap_en_q)
		else $error("buffer written without an accepted byte");

endmodule

FILE: tb/gga_capture_checker.sv
// Watches the request, response and config channels of the GGA capture block,
// keeps its own copy of the parser state and sentence buffer, and compares
// every response word against the oldest predicted one.
module gga_capture_checker #(
	parameter int unsigned DEPTH = ngsc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  ngsc_pkg::req_word_t req,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  ngsc_pkg::rsp_word_t rsp,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output int unsigned         waiting,
	output int unsigned         fails
);

	import ngsc_pkg::*;

	typedef enum logic [3:0] {
		PS_INIT, PS_DOLLAR, PS_G1, PS_P, PS_G2, PS_G3, PS_A, PS_COMMA, PS_DATA, PS_WAIT
	} parse_st_e;

	// mirrored block state
	logic        capture_on;
	parse_st_e   pstate;
	logic [7:0]  sentence [DEPTH];
	logic [6:0]  wr_idx;
	logic        good_flag;
	logic        read_seen;

	rsp_word_t   pending_rsp [$];
	rsp_word_t   want;
	int unsigned fail_n;

	// letters, digits and , $ . *
	function automatic bit is_sentence_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
			c == CH_COMMA || c == CH_DOLLAR || c == CH_DOT || c == CH_STAR;
	endfunction

	task automatic go_idle();
		pstate = PS_DOLLAR;
		read_seen = 1'b0;
	endtask

	task automatic match_or_idle(input logic [7:0] c, input logic [7:0] want_c,
		input parse_st_e nxt);
		if (c == want_c) pstate = nxt;
		else go_idle();
	endtask

	// one filtered character through the sentence matcher
	task automatic feed_char(input logic [7:0] c);
		case (pstate)
			PS_INIT: begin
				for (int k = 0; k < DEPTH; k++) sentence[k] = CH_DOLLAR;
				wr_idx = '0;
				go_idle();
			end
			PS_DOLLAR: begin
				if (c == CH_DOLLAR) pstate = PS_G1;
			end
			PS_G1: match_or_idle(c, CH_G, PS_P);
			PS_P:  match_or_idle(c, CH_P, PS_G2);
			PS_G2: match_or_idle(c, CH_G, PS_G3);
			PS_G3: match_or_idle(c, CH_G, PS_A);
			PS_A:  match_or_idle(c, CH_A, PS_COMMA);
			PS_COMMA: begin
				if (c == CH_COMMA) begin
					pstate = PS_DATA;
					wr_idx = '0;
					read_seen = 1'b0;
				end else begin
					go_idle();
				end
			end
			PS_DATA: begin
				// bytes past the end of the buffer are dropped
				if (int'(wr_idx) < DEPTH) begin
					sentence[int'(wr_idx)] = c;
					wr_idx = wr_idx + 7'd1;
				end
				if (c == CH_DOLLAR) begin
					good_flag = 1'b1;
					pstate = PS_WAIT;
				end
			end
			PS_WAIT: begin
				if (read_seen) begin
					good_flag = 1'b0;
					go_idle();
				end
			end
			default: go_idle();
		endcase
	endtask

	// expected response words for one accepted request word
	task automatic predict_request(input req_word_t w);
		rsp_word_t e;
		case (w.op)
			OP_BYTE: begin
				if (capture_on && is_sentence_char(w.rx_byte)) feed_char(w.rx_byte);
			end
			OP_READ: begin
				for (int k = 0; k < DEPTH; k++) begin
					e.data_char = sentence[k];
					e.position  = POS_W'(k);
					e.last      = (k == DEPTH - 1);
					e.good      = good_flag;
					pending_rsp.push_back(e);
				end
				read_seen = 1'b1;
			end
			OP_STAT: begin
				e.data_char = '0;
				e.position  = '0;
				e.last      = 1'b1;
				e.good      = good_flag;
				pending_rsp.push_back(e);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			fail_n++;
		end
	endtask

	// sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_on = 1'b0;
			pstate     = PS_INIT;
			for (int k = 0; k < DEPTH; k++) sentence[k] = CH_DOLLAR;
			wr_idx     = '0;
			good_flag  = 1'b1;
			read_seen  = 1'b0;
			fail_n     = 0;
			pending_rsp.delete();
			waiting <= 0;
			fails   <= 0;
		end else begin
			if (cfg_we) capture_on = cfg_wdata;
			if (req_valid && req_ready) predict_request(req);
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected response word, expected none, actual %p",
						$time, rsp);
					fail_n++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("data_char", want.data_char, rsp.data_char);
					check_field("position", want.position, rsp.position);
					check_field("last", want.last, rsp.last);
					check_field("good", want.good, rsp.good);
				end
			end
			waiting <= pending_rsp.size();
			fails   <= fail_n;
		end
	end

endmodule

FILE: tb/nmea_gga_sentence_capture_tb.sv
module nmea_gga_sentence_capture_tb;

	import ngsc_pkg::*;

	localparam int unsigned DEPTH       = BUFFER_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned WORD_TARGET = 420;
	localparam logic [1:0]  OP_NONE     = 2'd3;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_word_t   req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_word_t   rsp;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;

	int unsigned waiting;
	int unsigned fails;
	int unsigned cycles    = 0;
	int          n_words   = 0;
	bit          stall_on  = 1'b1;
	logic [7:0]  gga_head [7];

	nmea_gga_sentence_capture #(.BUFFER_DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gga_capture_checker #(.DEPTH(DEPTH)) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.waiting   (waiting),
		.fails     (fails)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side: random back-pressure while stalling is on
	always @(posedge clk) begin
		rsp_ready <= stall_on ? ($urandom_range(99) >= 26) : 1'b1;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one request word, with an occasional idle gap ahead of it
	task automatic send_word(input logic [1:0] op, input logic [7:0] c);
		if (stall_on && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{op: op, rx_byte: c};
		do @(posedge clk); while (!req_ready);
		n_words++;
	endtask

	// config write once nothing is in flight
	task automatic set_capture(input logic v);
		req_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_head();
		for (int k = 0; k < 7; k++) send_word(OP_BYTE, gga_head[k]);
	endtask

	// random sentence body character other than '$'
	function automatic logic [7:0] body_char();
		int r;
		r = $urandom_range(65, 0);
		if (r < 26) return 8'h41 + 8'(r);
		if (r < 52) return 8'h61 + 8'(r - 26);
		if (r < 62) return 8'h30 + 8'(r - 52);
		if (r == 62) return CH_COMMA;
		if (r == 63) return CH_DOT;
		return CH_STAR;
	endfunction

	initial begin
		int phase;
		int phase_start;
		int len;
		int r;

		gga_head = '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A, CH_COMMA};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: capture off, then a clean sentence and its read-out
		send_word(OP_STAT, 8'h00);
		send_word(OP_READ, 8'hFF);
		send_word(OP_BYTE, CH_A);
		set_capture(1'b1);
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_BYTE, "x");
		send_head();
		send_word(OP_BYTE, "1");
		send_word(OP_BYTE, CH_DOT);
		send_word(OP_BYTE, CH_STAR);
		send_word(OP_BYTE, CH_DOLLAR);
		send_word(OP_STAT, 8'h00);
		send_word(OP_READ, 8'h00);
		send_word(OP_NONE, 8'hFF);
		send_word(OP_BYTE, "9");
		// mismatch inside the header
		send_word(OP_BYTE, CH_DOLLAR);
		send_word(OP_BYTE, CH_G);
		send_word(OP_BYTE, "X");
		send_word(OP_STAT, 8'h00);

		// random phases
		n_words     = 0;
		phase       = 0;
		phase_start = 0;
		while (n_words < WORD_TARGET) begin
			if (n_words - phase_start >= 60) begin
				phase++;
				set_capture((phase % 5 == 2) ? 1'b0 : ($urandom_range(9) != 0));
				stall_on    = (phase % 4 != 3);
				phase_start = n_words;
			end
			r = $urandom_range(99);
			if (r < 60) begin
				// well-formed sentence, sometimes oversized, sometimes read mid-capture
				send_head();
				len = ($urandom_range(9) == 0) ? $urandom_range(70, 50) : $urandom_range(20, 0);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(99) < 3) send_word(OP_READ, 8'($urandom));
					send_word(OP_BYTE, body_char());
				end
				send_word(OP_BYTE, CH_DOLLAR);
				if ($urandom_range(1)) send_word(OP_STAT, 8'($urandom));
				if ($urandom_range(3) != 0) send_word(OP_READ, 8'($urandom));
				send_word(OP_BYTE, body_char());
			end else if (r < 75) begin
				// header broken after a random prefix
				len = $urandom_range(6, 1);
				for (int k = 0; k < len; k++) send_word(OP_BYTE, gga_head[k]);
				send_word(OP_BYTE, body_char());
			end else if (r < 85) begin
				send_word($urandom_range(1) ? OP_READ : OP_STAT, 8'($urandom));
			end else begin
				// noise words, mostly ignored by the block
				len = $urandom_range(4, 1);
				for (int k = 0; k < len; k++) begin
					send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
					n_words--;
				end
			end
		end

		// drain
		req_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: nmea_gga_sentence_capture.f
rtl/ngsc_pkg.sv
rtl/ngsc_parse.sv
rtl/ngsc_ctrl.sv
rtl/ngsc_dp.sv
rtl/nmea_gga_sentence_capture.sv
tb/gga_capture_checker.sv
tb/nmea_gga_sentence_capture_tb.sv
